// ===== rtl/running_median_two_heaps_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the running median design.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEDIAN_TWO_HEAPS_UNIT_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMTH_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running median assertion failed");

// Next-cycle implication, disabled during reset.
`define RMTH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("running median assertion failed");

`endif

// ===== rtl/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// rmth_pkg
// Types and constants shared by the running median design.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int IN_W     = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 11;

  // Heap selection codes.
  localparam logic HEAP_LOWER = 1'b0;
  localparam logic HEAP_UPPER = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_FIN
  } rmth_state_t;

endpackage

// ===== rtl/rmth_if.sv =====
// ----------------------------------------------------------------------------
// rmth_in_if / rmth_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface rmth_in_if;
  import rmth_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface rmth_out_if;
  import rmth_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_twice;
  logic [COUNT_W-1:0]         held_count;
  logic                       rejected;
  modport source (output valid, output median_twice, output held_count,
                  output rejected, input ready);
  modport sink (input valid, input median_twice, input held_count,
                input rejected, output ready);
endinterface

// ===== rtl/rmth_heap_ram.sv =====
// ----------------------------------------------------------------------------
// rmth_heap_ram
// Heap storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmth_heap_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/running_median_two_heaps_unit.sv =====
// ----------------------------------------------------------------------------
// running_median_two_heaps_unit
// Running median over a stream of samples using a max-heap and a min-heap.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the samples channel, one signed value per
// transaction. For each sample exactly one transaction leaves on the results
// channel with twice the median, the number of samples held and a rejected
// flag (set when the store already holds CAPACITY samples).
// Each sample is handled by a sequencer driving one shared compare unit over
// the heap memories: an optional sift-down of one heap (states DN_RDL, DN_RDR
// and DN_CMP per level) followed by a sift-up into the other heap (states
// UP_RD and UP_CMP per level), then the final state FIN to post the result.
// A rejected sample goes straight to FIN.
// The samples channel is ready only while the sequencer is idle.
// A finished result sits in an output register; a new sample may be taken
// while it waits, and the next result holds in the final state until the
// receiver takes the previous one.
// Reset clears the heap sizes and the output valid; the heap memories need
// no clearing, since entries past a heap's size are never used.
// ----------------------------------------------------------------------------
module running_median_two_heaps_unit #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  rmth_in_if.sink  samples,
  rmth_out_if.source results
);
  import rmth_pkg::*;

  localparam int HALF = (CAPACITY + 1) / 2;
  localparam int AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int SW   = $clog2(HALF + 1);
  localparam int XW   = AW + 2;

  rmth_state_t state, state_next;

  logic                         sel;
  logic                         push_sel;
  logic signed [VALUE_BITS-1:0] cur;
  logic signed [VALUE_BITS-1:0] pushv;
  logic signed [VALUE_BITS-1:0] best_val;
  logic [AW-1:0]                best_idx;
  logic                         best_moved;
  logic [AW-1:0]                idx;
  logic [SW-1:0]                lsz, usz;
  logic signed [VALUE_BITS-1:0] ltop, utop;
  logic                         rej;

  logic                         out_valid;
  logic signed [MEDIAN_W-1:0]   out_median;
  logic [COUNT_W-1:0]           out_count;
  logic                         out_rej;

  // Memory ports.
  logic [AW-1:0]                raddr, waddr;
  logic                         wen;
  logic [VALUE_BITS-1:0]        wdata;
  logic [VALUE_BITS-1:0]        rd_lower, rd_upper;
  logic signed [VALUE_BITS-1:0] rd;

  // Shared comparator.
  logic signed [VALUE_BITS-1:0] cmp_a, cmp_b;
  logic                         cmp_before;

  logic                         accept;
  logic signed [VALUE_BITS-1:0] v_in;
  logic [SW:0]                  total;
  logic                         full;
  logic                         go_lower;
  logic                         dec_down;
  logic                         dec_dsel;
  logic                         dec_psel;
  logic [SW-1:0]                cur_size;
  logic [AW:0]                  child_l;
  logic [XW-1:0]                child_r;
  logic                         l_ok, r_ok;
  logic [AW-1:0]                parent;
  logic                         take_r;
  logic                         fin_moved;
  logic [AW-1:0]                fin_idx;
  logic signed [VALUE_BITS-1:0] fin_val;
  logic signed [VALUE_BITS:0]   med;
  logic                         fin_go;

  rmth_heap_ram #(.DEPTH(HALF), .AW(AW), .W(VALUE_BITS)) u_lower (
    .clk   (clk),
    .we    (wen && (sel == HEAP_LOWER)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_lower)
  );

  rmth_heap_ram #(.DEPTH(HALF), .AW(AW), .W(VALUE_BITS)) u_upper (
    .clk   (clk),
    .we    (wen && (sel == HEAP_UPPER)),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_upper)
  );

  // Input decode and placement decision.
  assign accept   = samples.valid && samples.ready;
  assign v_in     = $signed(samples.value[VALUE_BITS-1:0]);
  assign total    = (SW + 1)'(lsz) + (SW + 1)'(usz);
  assign full     = 32'(total) >= 32'(CAPACITY);
  assign go_lower = (lsz == '0) || (v_in < ltop);

  always_comb begin
    dec_down = 1'b0;
    dec_dsel = HEAP_LOWER;
    dec_psel = HEAP_LOWER;
    if (go_lower) begin
      if (lsz > usz) begin
        dec_down = 1'b1;
        dec_dsel = HEAP_LOWER;
        dec_psel = HEAP_UPPER;
      end
    end else if (usz >= lsz) begin
      if (!((usz == '0) || (v_in <= utop))) begin
        dec_down = 1'b1;
        dec_dsel = HEAP_UPPER;
        dec_psel = HEAP_LOWER;
      end
    end else begin
      dec_psel = HEAP_UPPER;
    end
  end

  // Heap index arithmetic.
  assign cur_size = (sel == HEAP_UPPER) ? usz : lsz;
  assign child_l  = {idx, 1'b1};
  assign child_r  = XW'(child_l) + XW'(1);
  assign l_ok     = XW'(child_l) < XW'(cur_size);
  assign r_ok     = child_r < XW'(cur_size);
  assign parent   = AW'((idx - AW'(1)) >> 1);
  assign rd       = (sel == HEAP_UPPER) ? $signed(rd_upper) : $signed(rd_lower);

  // Comparator: true when a belongs nearer the root than b.
  assign cmp_before = (sel == HEAP_UPPER) ? (cmp_a < cmp_b) : (cmp_a > cmp_b);

  // Sift-down choice at the right child.
  assign take_r    = r_ok && cmp_before;
  assign fin_moved = take_r || best_moved;
  assign fin_idx   = take_r ? child_r[AW-1:0] : best_idx;
  assign fin_val   = take_r ? rd : best_val;

  assign fin_go = !out_valid || results.ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            state_next = ST_FIN;
          end else if (dec_down) begin
            state_next = ST_DN_RDL;
          end else begin
            state_next = ST_UP_RD;
          end
        end
      end
      ST_DN_RDL: state_next = ST_DN_RDR;
      ST_DN_RDR: state_next = ST_DN_CMP;
      ST_DN_CMP: state_next = fin_moved ? ST_DN_RDL : ST_UP_RD;
      ST_UP_RD:  state_next = (idx == '0) ? ST_FIN : ST_UP_CMP;
      ST_UP_CMP: state_next = cmp_before ? ST_UP_RD : ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory and comparator controls.
  always_comb begin
    raddr = child_l[AW-1:0];
    waddr = idx;
    wen   = 1'b0;
    wdata = cur;
    cmp_a = rd;
    cmp_b = cur;
    case (state)
      ST_DN_RDR: begin
        raddr = child_r[AW-1:0];
        cmp_b = cur;
      end
      ST_DN_CMP: begin
        cmp_b = best_val;
        wen   = 1'b1;
        wdata = fin_val;
      end
      ST_UP_RD: begin
        raddr = parent;
        wen   = (idx == '0);
      end
      ST_UP_CMP: begin
        cmp_a = cur;
        cmp_b = rd;
        wen   = 1'b1;
        wdata = cmp_before ? rd : cur;
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      lsz   <= '0;
      usz   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rej <= full;
            cur <= v_in;
            if (!full) begin
              push_sel <= dec_psel;
              if (dec_down) begin
                sel   <= dec_dsel;
                idx   <= '0;
                pushv <= (dec_dsel == HEAP_UPPER) ? utop : ltop;
              end else begin
                sel <= dec_psel;
                if (dec_psel == HEAP_UPPER) begin
                  idx <= usz[AW-1:0];
                  usz <= usz + SW'(1);
                end else begin
                  idx <= lsz[AW-1:0];
                  lsz <= lsz + SW'(1);
                end
              end
            end
          end
        end
        ST_DN_RDR: begin
          best_moved <= l_ok && cmp_before;
          best_val   <= (l_ok && cmp_before) ? rd : cur;
          best_idx   <= (l_ok && cmp_before) ? child_l[AW-1:0] : idx;
        end
        ST_DN_CMP: begin
          if (fin_moved) begin
            idx <= fin_idx;
          end else begin
            sel <= push_sel;
            cur <= pushv;
            if (push_sel == HEAP_UPPER) begin
              idx <= usz[AW-1:0];
              usz <= usz + SW'(1);
            end else begin
              idx <= lsz[AW-1:0];
              lsz <= lsz + SW'(1);
            end
          end
        end
        ST_UP_CMP: begin
          if (cmp_before) begin
            idx <= parent;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Root mirrors, kept in step with writes to entry zero.
  always_ff @(posedge clk) begin
    if (wen && (waddr == '0)) begin
      if (sel == HEAP_UPPER) begin
        utop <= wdata;
      end else begin
        ltop <= wdata;
      end
    end
  end

  // Median from the two roots.
  always_comb begin
    if (lsz == '0) begin
      med = '0;
    end else if (lsz == usz) begin
      med = (VALUE_BITS + 1)'(ltop) + (VALUE_BITS + 1)'(utop);
    end else begin
      med = {ltop, 1'b0};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FIN) && fin_go) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && fin_go) begin
      out_median <= MEDIAN_W'(med);
      out_count  <= COUNT_W'(total);
      out_rej    <= rej;
    end
  end

  assign samples.ready        = (state == ST_IDLE);
  assign results.valid        = out_valid;
  assign results.median_twice = out_median;
  assign results.held_count   = out_count;
  assign results.rejected     = out_rej;

  // Checks.
  `include "running_median_two_heaps_unit_defines.svh"

  `RMTH_ASSERT_IMPL(a_balance, clk, rst, 1'b1, (lsz == usz) || (lsz == usz + SW'(1)))
  `RMTH_ASSERT_IMPL(a_capacity, clk, rst, 1'b1, 32'(total) <= 32'(CAPACITY))
  `RMTH_ASSERT_NEXT(a_busy, clk, rst, accept, state != ST_IDLE)
  `RMTH_ASSERT_NEXT(a_post, clk, rst, (state == ST_FIN) && fin_go, out_valid)

endmodule
